/* rtl/counter_iv_checksum_framer_defines.svh */
// assertion macros for the framer
`ifndef COUNTER_IV_CHECKSUM_FRAMER_DEFINES_SVH
`define COUNTER_IV_CHECKSUM_FRAMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CICF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CICF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cicf_pkg.sv */
// shared types and constants for the counter iv checksum framer
package cicf_pkg;

    localparam logic [7:0] START_MARK = 8'hAA;
    localparam logic [7:0] END_MARK   = 8'h55;

    localparam int HDR_BYTES = 20;

    typedef logic [4:0] t_step;

    // position of the byte being emitted within one request
    localparam t_step STEP_START   = 5'd0;
    localparam t_step STEP_PAYLOAD = 5'd20;
    localparam t_step STEP_CHECK   = 5'd21;
    localparam t_step STEP_END     = 5'd22;

    localparam logic [63:0] IV_HIGH_RESET = 64'h0001020304050607;
    localparam logic [31:0] IV_LOW_RESET  = 32'h08090A0B;

    typedef enum logic [7:0] {
        CFG_IV_HIGH = 8'd0,
        CFG_IV_LOW  = 8'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [7:0]  mode_tag;
        logic [15:0] payload_length;
        logic        is_first;
        logic        is_last;
    } t_in;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_of_item;
        logic       end_of_frame;
    } t_out;

    // request as queued between front and back
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [7:0]  mode_tag;
        logic [15:0] payload_length;
        logic        opens_frame;
        logic        closes_frame;
    } t_cmd;

endpackage

/* rtl/cicf_front.sv */
// front end: accepts requests and queues them for the sequencer
module cicf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cicf_pkg::t_in   i_data,
    output logic            o_stall,
    output logic            o_cmd_valid,
    output cicf_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_pop
);

    cicf_pkg::t_cmd r_queue [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           n_wr_ptr;
    logic           n_rd_ptr;
    logic [1:0]     n_count;
    logic           push;
    cicf_pkg::t_cmd cmd_in;

    assign o_stall     = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign push        = i_valid && !o_stall;

    always_comb begin
        cmd_in.payload_byte   = i_data.payload_byte;
        cmd_in.mode_tag       = i_data.mode_tag;
        cmd_in.payload_length = i_data.payload_length;
        cmd_in.opens_frame    = i_data.is_first;
        cmd_in.closes_frame   = i_data.is_last;

        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_cmd_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push && !i_cmd_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_cmd_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

/* rtl/cicf_back.sv */
// back end: byte sequencer with frame counter, checksum and output register
module cicf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  cicf_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    input  logic [63:0]     i_iv_high,
    input  logic [31:0]     i_iv_low,
    output logic            o_valid,
    output cicf_pkg::t_out  o_data,
    input  logic            i_stall
);

    logic             r_busy;
    cicf_pkg::t_step  r_step;
    logic [31:0]      r_frame_count;
    logic [7:0]       r_xor;
    logic             r_out_valid;
    cicf_pkg::t_out   r_out;

    logic             n_busy;
    cicf_pkg::t_step  n_step;
    logic [31:0]      n_frame_count;
    logic [7:0]       n_xor;
    logic             n_out_valid;
    cicf_pkg::t_out   n_out;

    cicf_pkg::t_step  cur_step;
    cicf_pkg::t_step  hdr_sel;
    logic [159:0]     hdr;
    logic [7:0]       cur_byte;
    logic             advance;
    logic             item_done;

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        cur_step = r_busy ? r_step
                 : (i_cmd.opens_frame ? cicf_pkg::STEP_START : cicf_pkg::STEP_PAYLOAD);
        // counter bytes read the value already bumped on the start byte
        hdr = {cicf_pkg::START_MARK, i_cmd.mode_tag, i_cmd.payload_length,
               i_iv_high, i_iv_low, r_frame_count};
        hdr_sel = cicf_pkg::t_step'(cicf_pkg::HDR_BYTES - 1) - cur_step;

        case (cur_step)
            cicf_pkg::STEP_PAYLOAD: cur_byte = i_cmd.payload_byte;
            cicf_pkg::STEP_CHECK:   cur_byte = r_xor;
            cicf_pkg::STEP_END:     cur_byte = cicf_pkg::END_MARK;
            default:                cur_byte = hdr[{hdr_sel, 3'b000} +: 8];
        endcase

        advance   = i_cmd_valid && (!r_out_valid || !i_stall);
        item_done = ((cur_step == cicf_pkg::STEP_PAYLOAD) && !i_cmd.closes_frame)
                 || (cur_step == cicf_pkg::STEP_END);
        o_cmd_pop = advance && item_done;

        n_busy        = r_busy;
        n_step        = r_step;
        n_frame_count = r_frame_count;
        n_xor         = r_xor;
        n_out_valid   = r_out_valid && i_stall;
        n_out         = r_out;

        if (advance) begin
            n_busy      = !item_done;
            n_step      = cur_step + cicf_pkg::t_step'(1);
            n_out_valid = 1'b1;
            n_out.frame_byte   = cur_byte;
            n_out.last_of_item = item_done;
            n_out.end_of_frame = (cur_step == cicf_pkg::STEP_END);

            if (cur_step == cicf_pkg::STEP_START) begin
                n_frame_count = r_frame_count + 32'd1;
                n_xor         = 8'h00;
            end else if (cur_step <= cicf_pkg::STEP_PAYLOAD) begin
                n_xor = r_xor ^ cur_byte;
            end else if (cur_step == cicf_pkg::STEP_END) begin
                n_xor = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_step        <= cicf_pkg::STEP_START;
            r_frame_count <= 32'd0;
            r_xor         <= 8'h00;
            r_out_valid   <= 1'b0;
        end else begin
            r_busy        <= n_busy;
            r_step        <= n_step;
            r_frame_count <= n_frame_count;
            r_xor         <= n_xor;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

/* rtl/counter_iv_checksum_framer.sv */
// top level of the counter iv checksum framer
//
//  channel   signals                              direction
//  input     i_valid, o_stall, i_data (t_in)      in, one payload byte per request
//  output    o_valid, i_stall, o_data (t_out)     out, one frame byte per transfer
//  config    i_cfg_valid, o_cfg_ready, i_cfg_*    in, index 0 iv high, 1 iv low
//
// every valid output cycle carries one frame byte: a payload-only request yields one byte,
// a first byte 21, a last byte 3 and a first-and-last byte 23 frame bytes from the
// back-end sequencer. a two-entry queue decouples input from the sequencer, and the
// output register loads whenever a request is queued and it is empty or being
// drained. reset is synchronous and clears counter, checksum, queue and sequencer;
// the iv prefix returns to its default value. config writes are always ready.
module counter_iv_checksum_framer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cicf_pkg::t_in   i_data,
    output logic            o_stall,
    output logic            o_valid,
    output cicf_pkg::t_out  o_data,
    input  logic            i_stall,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [7:0]      i_cfg_index,
    input  logic [63:0]     i_cfg_data
);

`include "counter_iv_checksum_framer_defines.svh"

    logic [63:0]    r_iv_high;
    logic [31:0]    r_iv_low;
    logic           cmd_valid;
    logic           cmd_pop;
    cicf_pkg::t_cmd cmd;
    logic           cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv_high <= cicf_pkg::IV_HIGH_RESET;
            r_iv_low  <= cicf_pkg::IV_LOW_RESET;
        end else if (cfg_write) begin
            if (i_cfg_index == cicf_pkg::CFG_IV_HIGH) begin
                r_iv_high <= i_cfg_data;
            end
            if (i_cfg_index == cicf_pkg::CFG_IV_LOW) begin
                r_iv_low <= i_cfg_data[31:0];
            end
        end
    end

    cicf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    cicf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_iv_high   (r_iv_high),
        .i_iv_low    (r_iv_low),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

    // closing byte ends its request and carries the end mark
    `CICF_ASSERT_NOW(a_eof_byte, i_clk, i_rst_n, o_valid && o_data.end_of_frame, o_data.last_of_item && (o_data.frame_byte == cicf_pkg::END_MARK), "end of frame without end mark")

    // a full queue means the sequencer has work, so output must be valid next cycle
    `CICF_ASSERT_NEXT(a_full_drains, i_clk, i_rst_n, o_stall, o_valid, "queue full but no output")

    // nothing is popped from an empty queue
    `CICF_ASSERT_NOW(a_pop_valid, i_clk, i_rst_n, cmd_pop, cmd_valid, "pop from empty queue")

endmodule
